// ===== hdl/lmp_pkg.sv =====
// Shared types and constants of the longest monotone path block.
// Depends on nothing; lmp_ctrl, lmp_dp and the top level import it.
`default_nettype none
package lmp_pkg;
  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_MAX_COLS = 128;
  localparam int DATA_W = 15;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] DIM_RESET = 8'd128;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RSELF,
    ST_NB,
    ST_EVAL,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load_we;
    logic       load_done;
    logic       cell_zero;
    logic       cell_step;
    logic       clear_we;
    logic       rd_nb;
    logic [1:0] nb_sel;
    logic       self_cap;
    logic       nb_eval;
    logic       sweep_init;
    logic       write_back;
    logic       result_load;
  } cmd_t;

  typedef struct packed {
    logic at_last;
    logic changed;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

// ===== hdl/lmp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module lmp_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16384
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/lmp_ctrl.sv =====
// Controller state machine of the longest monotone path block.
// Depends on lmp_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none
module lmp_ctrl
  import lmp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire logic    last_cell,
  output logic         item_stall,
  input  wire status_t status,
  output cmd_t         cmd
);
  state_t     state, state_next;
  logic [1:0] nb, nb_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nb <= 2'd0;
    end else begin
      state <= state_next;
      nb <= nb_next;
    end
  end

  assign item_stall = (state != ST_IDLE);
  assign accept = item_valid & ~item_stall;

  always_comb begin
    state_next = state;
    nb_next = nb;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_we = 1'b1;
          if (last_cell) begin
            cmd.load_done = 1'b1;
            cmd.cell_zero = 1'b1;
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.at_last) begin
          cmd.cell_zero = 1'b1;
          cmd.sweep_init = 1'b1;
          state_next = ST_RSELF;
        end else begin
          cmd.cell_step = 1'b1;
        end
      end
      ST_RSELF: begin
        nb_next = 2'd0;
        state_next = ST_NB;
      end
      ST_NB: begin
        cmd.rd_nb = 1'b1;
        cmd.nb_sel = nb;
        if (nb == 2'd0) begin
          cmd.self_cap = 1'b1;
        end else begin
          cmd.nb_eval = 1'b1;
        end
        nb_next = nb + 2'd1;
        if (nb == 2'd3) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.nb_eval = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.write_back = 1'b1;
        state_next = ST_RSELF;
        if (status.at_last) begin
          cmd.cell_zero = 1'b1;
          if (status.changed) begin
            cmd.sweep_init = 1'b1;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          cmd.cell_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.result_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/lmp_dp.sv =====
// Datapath of the longest monotone path block: registers, counters and two RAMs.
// Depends on lmp_pkg and lmp_ram; follows commands from lmp_ctrl.
`default_nettype none
module lmp_dp
  import lmp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [DATA_W-1:0]    height,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic [DATA_W-1:0]         longest_path,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  input  wire cmd_t                 cmd,
  output status_t                   status
);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW = $clog2(CELLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  function automatic logic [RW-1:0] clamp_rows(logic [CFG_W-1:0] v);
    if (v == '0) return RW'(1);
    if (int'(v) > MAX_ROWS) return RW'(MAX_ROWS);
    return RW'(v);
  endfunction

  function automatic logic [CW-1:0] clamp_cols(logic [CFG_W-1:0] v);
    if (v == '0) return CW'(1);
    if (int'(v) > MAX_COLS) return CW'(MAX_COLS);
    return CW'(v);
  endfunction

  logic [CFG_W-1:0]  num_rows, num_cols;
  logic [RW-1:0]     rows, row;
  logic [CW-1:0]     cols, col;
  logic [PW-1:0]     cells, pos, idx;
  logic [PW-1:0]     nb_addr [4];
  logic [3:0]        nb_ok;
  logic [PW-1:0]     rd_idx;
  logic              nb_valid;
  logic [DATA_W-1:0] h_rd, l_rd, h_self, l_self, best, maxv, cand;
  logic              changed, improve;
  logic              h_we, l_we;
  logic [DATA_W-1:0] l_wdata;

  assign rows = clamp_rows(num_rows);
  assign cols = clamp_cols(num_cols);
  assign cells = PW'(rows) * PW'(cols);

  assign nb_addr[0] = idx - PW'(cols);
  assign nb_addr[1] = idx + PW'(cols);
  assign nb_addr[2] = idx - PW'(1);
  assign nb_addr[3] = idx + PW'(1);
  assign nb_ok[0] = (row != '0);
  assign nb_ok[1] = ((row + RW'(1)) < rows);
  assign nb_ok[2] = (col != '0);
  assign nb_ok[3] = ((col + CW'(1)) < cols);

  assign rd_idx = cmd.rd_nb ? nb_addr[cmd.nb_sel] : idx;
  assign cand = l_rd + DATA_W'(1);
  assign improve = best > l_self;

  assign h_we = cmd.load_we & (pos < cells);
  assign l_we = cmd.clear_we | (cmd.write_back & improve);
  assign l_wdata = cmd.clear_we ? DATA_W'(1) : best;

  lmp_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_height (
    .clk(clk), .we(h_we), .waddr(pos[AW-1:0]), .wdata(height),
    .raddr(rd_idx[AW-1:0]), .rdata(h_rd)
  );

  lmp_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_length (
    .clk(clk), .we(l_we), .waddr(idx[AW-1:0]), .wdata(l_wdata),
    .raddr(rd_idx[AW-1:0]), .rdata(l_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_RESET;
      num_cols <= DIM_RESET;
      pos <= '0;
      idx <= '0;
      row <= '0;
      col <= '0;
      result_valid <= 1'b0;
      changed <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_NUM_ROWS) num_rows <= cfg_data;
        if (cfg_index == REG_NUM_COLS) num_cols <= cfg_data;
      end
      if (cmd.load_done) begin
        pos <= '0;
      end else if (h_we) begin
        pos <= pos + PW'(1);
      end
      if (cmd.cell_zero) begin
        idx <= '0;
        row <= '0;
        col <= '0;
      end else if (cmd.cell_step) begin
        idx <= idx + PW'(1);
        if (col == cols - CW'(1)) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      if (cmd.sweep_init) begin
        changed <= 1'b0;
      end else if (cmd.write_back && improve) begin
        changed <= 1'b1;
      end
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    nb_valid <= cmd.rd_nb & nb_ok[cmd.nb_sel];
    if (cmd.self_cap) begin
      h_self <= h_rd;
      l_self <= l_rd;
      best <= DATA_W'(1);
    end else if (cmd.nb_eval && nb_valid && (h_rd > h_self) && (cand > best)) begin
      best <= cand;
    end
    if (cmd.sweep_init) begin
      maxv <= DATA_W'(1);
    end else if (cmd.write_back && (best > maxv)) begin
      maxv <= best;
    end
    if (cmd.result_load) begin
      longest_path <= maxv;
    end
  end

  assign status.at_last = (idx == cells - PW'(1));
  assign status.changed = changed | improve;
  assign status.out_busy = result_valid & result_stall;
endmodule
`default_nettype wire

// ===== hdl/grid_longest_monotone_path.sv =====
// Top level of the longest strictly increasing neighbor path block.
// Depends on lmp_pkg, lmp_ctrl and lmp_dp.
//
// Channel  | Handshake                 | Payload
// item     | item_valid / item_stall   | height, last_cell
// result   | result_valid / result_stall | longest_path
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// Heights load at one cell per cycle while the block is idle.
// After the last cell, a clearing pass sets every length to one, then each
// relaxation sweep visits the cells in order: a read of the cell, four
// neighbor reads, a compare and a write back.
// Sweeps repeat until one changes nothing: at most longest path plus one sweeps.
// Reset is synchronous; the item channel stalls during the computation.
`default_nettype none
module grid_longest_monotone_path
  import lmp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic [DATA_W-1:0]    height,
  input  wire logic                 last_cell,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [DATA_W-1:0]         longest_path,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lmp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .item_valid(item_valid), .last_cell(last_cell),
    .item_stall(item_stall), .status(status), .cmd(cmd)
  );

  lmp_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst), .height(height), .cfg_valid(cfg_valid),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .longest_path(longest_path),
    .result_valid(result_valid), .result_stall(result_stall),
    .cmd(cmd), .status(status)
  );
endmodule
`default_nettype wire
